>>> hw/rtl/http_chunked_body_decoder_defines.svh
// ---------------------------------------------------------------------------
// http_chunked_body_decoder_defines.svh
// Assertion macros shared by the chunked body decoder RTL.
// ---------------------------------------------------------------------------
`ifndef HTTP_CHUNKED_BODY_DECODER_DEFINES_SVH
`define HTTP_CHUNKED_BODY_DECODER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Checked property, switched off while reset is asserted.
`define HCBD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("hcbd assertion failed");

// Checked property that also holds during reset.
`define HCBD_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("hcbd assertion failed");

`else

`define HCBD_ASSERT(lbl, clk, rst_n, prop)
`define HCBD_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

>>> hw/rtl/hcbd_pkg.sv
// ---------------------------------------------------------------------------
// hcbd_pkg
// Types and constants shared by the chunked body decoder modules.
// ---------------------------------------------------------------------------
package hcbd_pkg;

    // Result status codes.
    localparam logic [1:0] STATUS_BUSY  = 2'd0;
    localparam logic [1:0] STATUS_DONE  = 2'd1;
    localparam logic [1:0] STATUS_ERROR = 2'd2;

    // One input item as held in the input register.
    typedef struct packed {
        logic       restart;
        logic [7:0] data_byte;
    } in_item_t;

    // One result item as held in the result register.
    typedef struct packed {
        logic [1:0] status;
        logic [7:0] body_byte;
        logic       body_valid;
    } result_t;

endpackage

>>> hw/rtl/hcbd_in_stage.sv
// ---------------------------------------------------------------------------
// hcbd_in_stage
// Input register that captures one item per cycle from the slave channel unless item_ready holds it full.
// ---------------------------------------------------------------------------
module hcbd_in_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  hcbd_pkg::in_item_t s_item,
    output logic               item_valid,
    input  logic               item_ready,
    output hcbd_pkg::in_item_t item
);

    logic               valid_reg;
    hcbd_pkg::in_item_t item_reg;

    // The register may be refilled whenever it is empty or being drained.
    assign s_tready   = !valid_reg || item_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    // Occupancy flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    // Payload capture; no reset needed.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= s_item;
        end
    end

endmodule

>>> hw/rtl/hcbd_decode.sv
// ---------------------------------------------------------------------------
// hcbd_decode
// Chunk framing state and the single-pass update applied to each byte.
// ---------------------------------------------------------------------------
module hcbd_decode #(
    parameter int SIZE_WIDTH  = 32,
    parameter int COUNT_WIDTH = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [31:0]        cfg_data,
    input  logic               item_valid,
    output logic               item_ready,
    input  hcbd_pkg::in_item_t item,
    output logic               res_valid,
    input  logic               res_ready,
    output hcbd_pkg::result_t  result
);

    localparam int CMP_W = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;
    localparam logic [7:0] BYTE_CR = 8'h0d;
    localparam logic [7:0] BYTE_LF = 8'h0a;

    typedef enum logic [2:0] {
        PH_SIZE    = 3'd0,
        PH_DATA    = 3'd1,
        PH_END_CR  = 3'd2,
        PH_END_LF  = 3'd3,
        PH_TRAILER = 3'd4,
        PH_DONE    = 3'd5,
        PH_ERROR   = 3'd6
    } phase_t;

    // Decodes an ASCII hex digit; bit 4 flags a valid digit.
    function automatic logic [4:0] hex_decode(input logic [7:0] b);
        logic [4:0] r;
        r = '0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, 4'(b - 8'h30)};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            r = {1'b1, 4'(b - 8'h57)};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            r = {1'b1, 4'(b - 8'h37)};
        end
        return r;
    endfunction

    logic [31:0]            max_body_reg;
    phase_t                 phase_reg, phase_next, phase_cur;
    logic [SIZE_WIDTH-1:0]  hex_value_reg, hex_value_next, hex_value_cur;
    logic                   saw_digit_reg, saw_digit_next, saw_digit_cur;
    logic                   stopped_reg, stopped_next, stopped_cur;
    logic                   overflow_reg, overflow_next, overflow_cur;
    logic                   pending_cr_reg, pending_cr_next, pending_cr_cur;
    logic [SIZE_WIDTH-1:0]  remaining_reg, remaining_next, remaining_cur;
    logic [COUNT_WIDTH-1:0] total_reg, total_next, total_cur;
    logic [1:0]             trailer_reg, trailer_next, trailer_cur;

    logic                   fire;
    logic [4:0]             digit;
    logic [SIZE_WIDTH-1:0]  remaining_dec;
    logic                   limit_hit;
    logic                   out_valid;
    logic [7:0]             out_byte;
    logic [7:0]             b;

    assign cfg_ready  = 1'b1;
    assign item_ready = res_ready;
    assign res_valid  = item_valid;
    assign fire       = item_valid && res_ready;
    assign b          = item.data_byte;
    assign digit      = hex_decode(b);

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_body_reg <= '0;
        end else if (cfg_valid) begin
            max_body_reg <= cfg_data;
        end
    end

    // State seen by this byte: restart clears everything first.
    always_comb begin
        if (item.restart) begin
            phase_cur      = PH_SIZE;
            hex_value_cur  = '0;
            saw_digit_cur  = 1'b0;
            stopped_cur    = 1'b0;
            overflow_cur   = 1'b0;
            pending_cr_cur = 1'b0;
            remaining_cur  = '0;
            total_cur      = '0;
            trailer_cur    = 2'd0;
        end else begin
            phase_cur      = phase_reg;
            hex_value_cur  = hex_value_reg;
            saw_digit_cur  = saw_digit_reg;
            stopped_cur    = stopped_reg;
            overflow_cur   = overflow_reg;
            pending_cr_cur = pending_cr_reg;
            remaining_cur  = remaining_reg;
            total_cur      = total_reg;
            trailer_cur    = trailer_reg;
        end
    end

    assign remaining_dec = remaining_cur - SIZE_WIDTH'(1);
    assign limit_hit     = (max_body_reg != 32'd0) &&
                           (CMP_W'(total_cur) >= CMP_W'(max_body_reg));

    // Per-byte state update.
    always_comb begin
        phase_next      = phase_cur;
        hex_value_next  = hex_value_cur;
        saw_digit_next  = saw_digit_cur;
        stopped_next    = stopped_cur;
        overflow_next   = overflow_cur;
        pending_cr_next = pending_cr_cur;
        remaining_next  = remaining_cur;
        total_next      = total_cur;
        trailer_next    = trailer_cur;
        out_valid       = 1'b0;
        out_byte        = 8'h00;

        unique case (phase_cur)
            PH_SIZE: begin
                if (b == BYTE_LF && pending_cr_cur) begin
                    // End of the size line: decide what follows.
                    if (!saw_digit_cur || overflow_cur) begin
                        phase_next = PH_ERROR;
                    end else if (hex_value_cur == '0) begin
                        phase_next   = PH_TRAILER;
                        trailer_next = 2'd2;
                    end else begin
                        phase_next     = PH_DATA;
                        remaining_next = hex_value_cur;
                    end
                    hex_value_next  = '0;
                    saw_digit_next  = 1'b0;
                    stopped_next    = 1'b0;
                    overflow_next   = 1'b0;
                    pending_cr_next = 1'b0;
                end else begin
                    pending_cr_next = (b == BYTE_CR);
                    if (!stopped_cur) begin
                        if (!digit[4]) begin
                            stopped_next = 1'b1;
                        end else begin
                            saw_digit_next = 1'b1;
                            if (!overflow_cur) begin
                                // A set top nibble means the shift would overflow.
                                if (hex_value_cur[SIZE_WIDTH-1 -: 4] != 4'd0) begin
                                    overflow_next = 1'b1;
                                end else begin
                                    hex_value_next = {hex_value_cur[SIZE_WIDTH-5:0],
                                                      digit[3:0]};
                                end
                            end
                        end
                    end
                end
            end
            PH_DATA: begin
                if (limit_hit) begin
                    phase_next = PH_ERROR;
                end else begin
                    out_valid      = 1'b1;
                    out_byte       = b;
                    remaining_next = remaining_dec;
                    if (!(&total_cur)) begin
                        total_next = total_cur + COUNT_WIDTH'(1);
                    end
                    if (remaining_dec == '0) begin
                        phase_next = PH_END_CR;
                    end
                end
            end
            PH_END_CR: begin
                phase_next = (b == BYTE_CR) ? PH_END_LF : PH_ERROR;
            end
            PH_END_LF: begin
                if (b == BYTE_LF) begin
                    phase_next      = PH_SIZE;
                    hex_value_next  = '0;
                    saw_digit_next  = 1'b0;
                    stopped_next    = 1'b0;
                    overflow_next   = 1'b0;
                    pending_cr_next = 1'b0;
                end else begin
                    phase_next = PH_ERROR;
                end
            end
            PH_TRAILER: begin
                // Track progress towards the closing CR LF CR LF.
                if (b == BYTE_CR) begin
                    trailer_next = (trailer_cur == 2'd2) ? 2'd3 : 2'd1;
                end else if (b == BYTE_LF) begin
                    if (trailer_cur == 2'd3) begin
                        phase_next   = PH_DONE;
                        trailer_next = 2'd0;
                    end else if (trailer_cur == 2'd1) begin
                        trailer_next = 2'd2;
                    end else begin
                        trailer_next = 2'd0;
                    end
                end else begin
                    trailer_next = 2'd0;
                end
            end
            PH_DONE, PH_ERROR: begin
                phase_next = phase_cur;
            end
            default: begin
                phase_next = PH_ERROR;
            end
        endcase
    end

    // Result formed from the updated phase.
    always_comb begin
        result.body_valid = out_valid;
        result.body_byte  = out_byte;
        if (phase_next == PH_DONE) begin
            result.status = hcbd_pkg::STATUS_DONE;
        end else if (phase_next == PH_ERROR) begin
            result.status = hcbd_pkg::STATUS_ERROR;
        end else begin
            result.status = hcbd_pkg::STATUS_BUSY;
        end
    end

    // Decoder state, advanced once per item passed on.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_SIZE;
            hex_value_reg  <= '0;
            saw_digit_reg  <= 1'b0;
            stopped_reg    <= 1'b0;
            overflow_reg   <= 1'b0;
            pending_cr_reg <= 1'b0;
            remaining_reg  <= '0;
            total_reg      <= '0;
            trailer_reg    <= 2'd0;
        end else if (fire) begin
            phase_reg      <= phase_next;
            hex_value_reg  <= hex_value_next;
            saw_digit_reg  <= saw_digit_next;
            stopped_reg    <= stopped_next;
            overflow_reg   <= overflow_next;
            pending_cr_reg <= pending_cr_next;
            remaining_reg  <= remaining_next;
            total_reg      <= total_next;
            trailer_reg    <= trailer_next;
        end
    end

endmodule

>>> hw/rtl/hcbd_out_stage.sv
// ---------------------------------------------------------------------------
// hcbd_out_stage
// Result register that holds one item for the master channel.
// ---------------------------------------------------------------------------
module hcbd_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              res_valid,
    output logic              res_ready,
    input  hcbd_pkg::result_t result,
    output logic              m_tvalid,
    input  logic              m_tready,
    output hcbd_pkg::result_t m_result
);

    logic              valid_reg;
    hcbd_pkg::result_t result_reg;

    // A new result may load when the register is empty or being taken.
    assign res_ready = !valid_reg || m_tready;
    assign m_tvalid  = valid_reg;
    assign m_result  = result_reg;

    // Occupancy flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (res_ready) begin
            valid_reg <= res_valid;
        end
    end

    // Payload capture.
    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            result_reg <= result;
        end
    end

endmodule

>>> hw/rtl/http_chunked_body_decoder.sv
// ---------------------------------------------------------------------------
// http_chunked_body_decoder
// Streaming decoder for an HTTP/1.1 chunked message body.
// ---------------------------------------------------------------------------
// Raw body bytes enter on the s_ channel, one item per byte, with s_tuser
// carrying the restart flag that clears the decoder before that byte. Every
// input item yields exactly one result item on the m_ channel: the decoded
// byte when it is chunk data, plus the running status (in progress, body
// complete, or error). The user must write max_body over the cfg_ channel
// while the decoder is idle (the block does not enforce it); zero disables
// the length limit. The block sustains one item per cycle while m_tready
// stays high. An accepted item is captured in the input register, decoded
// by the single-pass state update and then captured in the result register,
// which presents it on m_. When the receiver stalls, the result register
// holds its item and the input register fills behind it; s_tready then drops
// until m_tready returns. A synchronous reset empties both registers,
// returns the framing state to the size line and clears max_body.
// ---------------------------------------------------------------------------
`include "http_chunked_body_decoder_defines.svh"

module http_chunked_body_decoder #(
    parameter int SIZE_WIDTH  = 32,
    parameter int COUNT_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write channel: max_body.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    // Input channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] restart
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] body_byte
    output logic [2:0]  m_tuser    // [0] body_valid, [2:1] status
);

    hcbd_pkg::in_item_t s_item;
    hcbd_pkg::in_item_t item;
    hcbd_pkg::result_t  result;
    hcbd_pkg::result_t  m_result;
    logic               item_valid;
    logic               item_ready;
    logic               res_valid;
    logic               res_ready;

    assign s_item.data_byte = s_tdata;
    assign s_item.restart   = s_tuser;

    // Input register.
    hcbd_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item)
    );

    // Framing state and per-byte update.
    hcbd_decode #(
        .SIZE_WIDTH  (SIZE_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_decode (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .result     (result)
    );

    // Result register.
    hcbd_out_stage u_out_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .result    (result),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_result  (m_result)
    );

    assign m_tdata = m_result.body_byte;
    assign m_tuser = {m_result.status, m_result.body_valid};

    // A decoded data byte is only ever emitted while the body is in progress.
    `HCBD_ASSERT(a_data_in_progress, aclk, aresetn,
        (m_tvalid && m_tuser[0]) |-> (m_tuser[2:1] == hcbd_pkg::STATUS_BUSY))
    // The unused status code never appears.
    `HCBD_ASSERT(a_status_code, aclk, aresetn,
        m_tvalid |-> (m_tuser[2:1] != 2'd3))
    // Reset empties the result register.
    `HCBD_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid)
    // A result is never lost: a stalled result register blocks new input
    // once the input register is also occupied.
    `HCBD_ASSERT(a_stall_backpressure, aclk, aresetn,
        (m_tvalid && !m_tready && item_valid) |-> !s_tready)

endmodule

>>> test/http_chunked_body_decoder_checker.sv
// ---------------------------------------------------------------------------
// http_chunked_body_decoder_checker
// Watches the decoder's channels, predicts each result and compares it.
// ---------------------------------------------------------------------------
// Every item accepted on the s_ channel is run through a chunked framing
// predictor that keeps its own copy of the decoder state and of max_body.
// The predicted result is queued, and each item accepted on the m_ channel
// is compared field by field with the oldest queued result. The number of
// failures and the number of results still outstanding go to the top.
// ---------------------------------------------------------------------------
module http_chunked_body_decoder_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] restart
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // [7:0] body_byte
    input  logic [2:0]  m_tuser,   // [0] body_valid, [2:1] status
    output int          fail_count,
    output int          pending_count
);

    typedef enum logic [2:0] {
        FRAME_SIZE, FRAME_DATA, FRAME_END_CR, FRAME_END_LF,
        FRAME_TRAILER, FRAME_DONE, FRAME_ERROR
    } frame_phase_t;

    // How much of the closing CR LF CR LF has been seen in the trailer.
    typedef enum logic [1:0] {
        TRL_NONE, TRL_CR, TRL_CRLF, TRL_CRLFCR
    } trailer_state_t;

    localparam logic [7:0]  CHAR_CR     = 8'h0d;
    localparam logic [7:0]  CHAR_LF     = 8'h0a;
    localparam logic [31:0] SIZE_LIMIT  = 32'hffff_ffff;
    localparam logic [31:0] COUNT_LIMIT = 32'hffff_ffff;

    // Predictor state.
    logic [31:0]    body_limit;
    frame_phase_t   frame_phase;
    logic [31:0]    size_acc;
    logic           seen_digit;
    logic           digits_done;
    logic           size_too_big;
    logic           cr_pending;
    logic [31:0]    chunk_left;
    logic [31:0]    body_count;
    trailer_state_t trailer_state;

    hcbd_pkg::result_t expected_q[$];

    // Report one mismatch on a line of its own and count it.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch in %s: got 0x%0h, expected 0x%0h", what, got, want);
        fail_count++;
    endtask

    function automatic void clear_line();
        size_acc     = '0;
        seen_digit   = 1'b0;
        digits_done  = 1'b0;
        size_too_big = 1'b0;
        cr_pending   = 1'b0;
    endfunction

    function automatic void clear_framing();
        frame_phase   = FRAME_SIZE;
        clear_line();
        chunk_left    = '0;
        body_count    = '0;
        trailer_state = TRL_NONE;
    endfunction

    function automatic int hex_nibble(input logic [7:0] b);
        if (b >= "0" && b <= "9") return int'(b - "0");
        if (b >= "a" && b <= "f") return int'(b - "a") + 10;
        if (b >= "A" && b <= "F") return int'(b - "A") + 10;
        return -1;
    endfunction

    // One byte of a size line: hex digits up to the first other byte, CR LF ends it.
    function automatic void size_line_byte(input logic [7:0] b);
        int d;
        if (b == CHAR_LF && cr_pending) begin
            if (!seen_digit || size_too_big) begin
                frame_phase = FRAME_ERROR;
            end else if (size_acc == 0) begin
                frame_phase   = FRAME_TRAILER;
                trailer_state = TRL_CRLF;
            end else begin
                frame_phase = FRAME_DATA;
                chunk_left  = size_acc;
            end
            clear_line();
            return;
        end
        cr_pending = (b == CHAR_CR);
        if (digits_done) return;
        d = hex_nibble(b);
        if (d < 0) begin
            digits_done = 1'b1;
            return;
        end
        seen_digit = 1'b1;
        if (size_too_big) return;
        if (size_acc > ((SIZE_LIMIT - 32'(d)) >> 4))
            size_too_big = 1'b1;
        else
            size_acc = (size_acc << 4) + 32'(d);
    endfunction

    // One byte after the last chunk: the body is complete at CR LF CR LF.
    function automatic void trailer_byte(input logic [7:0] b);
        if (b == CHAR_CR) begin
            trailer_state = (trailer_state == TRL_CRLF) ? TRL_CRLFCR : TRL_CR;
        end else if (b == CHAR_LF) begin
            if (trailer_state == TRL_CRLFCR) begin
                frame_phase   = FRAME_DONE;
                trailer_state = TRL_NONE;
            end else if (trailer_state == TRL_CR) begin
                trailer_state = TRL_CRLF;
            end else begin
                trailer_state = TRL_NONE;
            end
        end else begin
            trailer_state = TRL_NONE;
        end
    endfunction

    // Advance the framing state by one raw byte and return its result item.
    function automatic hcbd_pkg::result_t decode_byte(input logic [7:0] b,
                                                      input logic restart);
        hcbd_pkg::result_t r;
        r = '0;
        if (restart) clear_framing();
        case (frame_phase)
            FRAME_SIZE: begin
                size_line_byte(b);
            end
            FRAME_DATA: begin
                if (body_limit != 0 && body_count >= body_limit) begin
                    frame_phase = FRAME_ERROR;
                end else begin
                    r.body_valid = 1'b1;
                    r.body_byte  = b;
                    if (body_count != COUNT_LIMIT) body_count++;
                    chunk_left--;
                    if (chunk_left == 0) frame_phase = FRAME_END_CR;
                end
            end
            FRAME_END_CR: begin
                frame_phase = (b == CHAR_CR) ? FRAME_END_LF : FRAME_ERROR;
            end
            FRAME_END_LF: begin
                if (b == CHAR_LF) begin
                    frame_phase = FRAME_SIZE;
                    clear_line();
                end else begin
                    frame_phase = FRAME_ERROR;
                end
            end
            FRAME_TRAILER: begin
                trailer_byte(b);
            end
            FRAME_DONE, FRAME_ERROR: begin
            end
            default: begin
                frame_phase = FRAME_ERROR;
            end
        endcase
        if (frame_phase == FRAME_DONE)
            r.status = hcbd_pkg::STATUS_DONE;
        else if (frame_phase == FRAME_ERROR)
            r.status = hcbd_pkg::STATUS_ERROR;
        else
            r.status = hcbd_pkg::STATUS_BUSY;
        return r;
    endfunction

    // Predict on every accepted input item, compare on every accepted result.
    always @(posedge aclk) begin : monitor
        hcbd_pkg::result_t got;
        hcbd_pkg::result_t want;
        if (!aresetn) begin
            body_limit = '0;
            clear_framing();
            expected_q.delete();
            pending_count <= 0;
        end else begin
            if (cfg_valid && cfg_ready) body_limit = cfg_data;
            if (s_tvalid && s_tready) expected_q.push_back(decode_byte(s_tdata, s_tuser));
            if (m_tvalid && m_tready) begin
                got = hcbd_pkg::result_t'({m_tuser[2:1], m_tdata, m_tuser[0]});
                if (expected_q.size() == 0) begin
                    report_mismatch("result item with none expected", 32'(got), 32'd0);
                end else begin
                    want = expected_q.pop_front();
                    if (got.body_valid !== want.body_valid)
                        report_mismatch("body_valid", 32'(got.body_valid),
                                        32'(want.body_valid));
                    if (got.body_byte !== want.body_byte)
                        report_mismatch("body_byte", 32'(got.body_byte),
                                        32'(want.body_byte));
                    if (got.status !== want.status)
                        report_mismatch("status", 32'(got.status), 32'(want.status));
                end
            end
            pending_count <= expected_q.size();
        end
    end

endmodule

>>> test/http_chunked_body_decoder_tb.sv
// ---------------------------------------------------------------------------
// http_chunked_body_decoder_tb
// Top level testbench for the chunked body decoder.
// ---------------------------------------------------------------------------
// Sends a few hand-built bodies, then several phases of random chunked
// bodies, mostly well formed with random sizes, extensions, data and
// trailers, the rest with framing faults or noise. Each phase takes its
// max_body from a list, written while the decoder is idle. Both channels idle
// at random, apart from one phase with no idling, in which the receiver also
// holds off for a long stretch. The checker beside the decoder does all
// prediction and comparison; this module only drives and gives the verdict.
// ---------------------------------------------------------------------------
module http_chunked_body_decoder_tb;

    localparam int          LIMIT_CYCLES = 400000;
    localparam int          LONG_STALL   = 80;
    localparam int          PHASE_ITEMS  = 260;
    localparam logic [7:0]  CHAR_CR      = 8'h0d;
    localparam logic [7:0]  CHAR_LF      = 8'h0a;

    // Faults that a random body may carry.
    typedef enum int {
        FLAW_NONE, FLAW_EMPTY_LINE, FLAW_OVERFLOW, FLAW_BAD_END,
        FLAW_NOISE, FLAW_TRUNCATE, FLAW_GARBLE
    } flaw_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [31:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic [7:0]  s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tready  = 1'b0;
    logic        cfg_ready;
    logic        s_tready;
    logic        m_tvalid;
    logic [7:0]  m_tdata;
    logic [2:0]  m_tuser;

    int          fail_count;
    int          pending_count;
    int          items_sent  = 0;
    int          cycle_count = 0;
    bit          idle_on     = 1'b1;
    bit          stall_req   = 1'b0;
    logic [7:0]  msg_bytes[$];
    logic [31:0] body_limits[8] = '{32'd0, 32'd1, 32'd16, 32'hffff_ffff,
                                    32'd0, 32'd5, 32'h8000_0000, 32'd0};

    always #1 aclk = ~aclk;

    http_chunked_body_decoder u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    http_chunked_body_decoder_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("** http_chunked_body_decoder: FAILED **");
            $finish;
        end
    end

    // Receiver: random back-pressure, or one long hold-off when asked for.
    initial begin : receiver
        forever begin
            @(posedge aclk);
            if (stall_req) begin
                m_tready  <= 1'b0;
                stall_req <= 1'b0;
                repeat (LONG_STALL - 1) @(posedge aclk);
            end else begin
                m_tready <= (idle_on && $urandom_range(99) < 29) ? 1'b0 : 1'b1;
            end
        end
    end

    // Offer one item, with a random gap before it, and wait until it is taken.
    task automatic send_byte(input logic [7:0] b, input logic restart_flag);
        while (idle_on && $urandom_range(99) < 29) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= restart_flag;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic send_queued(input bit with_restart);
        foreach (msg_bytes[i]) send_byte(msg_bytes[i], with_restart && (i == 0));
    endtask

    // Stop offering and wait until every expected result has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_max_body(input logic [31:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic void push_text(input string t);
        foreach (t[i]) msg_bytes.push_back(t[i]);
    endfunction

    function automatic void push_crlf();
        msg_bytes.push_back(CHAR_CR);
        msg_bytes.push_back(CHAR_LF);
    endfunction

    function automatic void push_printable(input int n);
        repeat (n) msg_bytes.push_back(8'($urandom_range(8'h20, 8'h7e)));
    endfunction

    // Size in hex, digits in random case, sometimes with leading zeros.
    function automatic void push_size(input logic [35:0] value);
        int         digits;
        logic [3:0] nib;
        digits = 1;
        while (digits < 9 && (value >> (4 * digits)) != 0) digits++;
        if ($urandom_range(9) == 0) digits += $urandom_range(1, 2);
        for (int i = digits - 1; i >= 0; i--) begin
            nib = 4'(value >> (4 * i));
            if (nib < 4'd10)
                msg_bytes.push_back("0" + 8'(nib));
            else
                msg_bytes.push_back(($urandom_range(1) ? "A" : "a") + 8'(nib) - 8'd10);
        end
    endfunction

    // Rest of a size line after the digits: an extension, stray CR or LF bytes, or nothing.
    function automatic void push_line_tail();
        int pick;
        pick = $urandom_range(99);
        if (pick < 25) begin
            msg_bytes.push_back(";");
            push_printable($urandom_range(0, 6));
        end else if (pick < 35) begin
            msg_bytes.push_back(CHAR_LF);
            push_printable($urandom_range(0, 2));
        end else if (pick < 45) begin
            msg_bytes.push_back(CHAR_CR);
            if ($urandom_range(1)) msg_bytes.push_back(CHAR_CR);
            else push_printable(1);
        end
    endfunction

    // Build one body, possibly with a fault, and send it.
    task automatic send_message();
        flaw_t       flaw;
        int          n_chunks;
        int          bad_at;
        int          len;
        logic [7:0]  b;
        bit          with_restart;
        msg_bytes.delete();
        flaw = ($urandom_range(99) < 75) ? FLAW_NONE : flaw_t'($urandom_range(1, 6));
        with_restart = ($urandom_range(99) < 92);
        case (flaw)
            FLAW_NOISE: begin
                repeat ($urandom_range(4, 16)) msg_bytes.push_back(8'($urandom));
            end
            FLAW_EMPTY_LINE: begin
                if ($urandom_range(1)) begin
                    msg_bytes.push_back(";");
                    push_printable($urandom_range(0, 4));
                end
                push_crlf();
                push_printable($urandom_range(0, 2));
            end
            FLAW_OVERFLOW: begin
                if ($urandom_range(1)) begin
                    push_size({4'($urandom_range(1, 15)), 32'($urandom)});
                    push_line_tail();
                    push_crlf();
                end else begin
                    // Largest size that still fits, followed by a few data bytes.
                    push_size(36'hffff_ffff);
                    push_crlf();
                    repeat ($urandom_range(1, 6)) msg_bytes.push_back(8'($urandom));
                end
            end
            default: begin
                n_chunks = $urandom_range((flaw == FLAW_BAD_END) ? 1 : 0, 3);
                bad_at   = (n_chunks > 0) ? $urandom_range(0, n_chunks - 1) : 0;
                for (int c = 0; c < n_chunks; c++) begin
                    len = ($urandom_range(9) == 0) ? $urandom_range(9, 64)
                                                   : $urandom_range(1, 8);
                    push_size(36'(len));
                    push_line_tail();
                    push_crlf();
                    repeat (len) msg_bytes.push_back(8'($urandom));
                    if (flaw == FLAW_BAD_END && c == bad_at) begin
                        if ($urandom_range(1)) begin
                            do b = 8'($urandom); while (b == CHAR_CR);
                            msg_bytes.push_back(b);
                        end else begin
                            msg_bytes.push_back(CHAR_CR);
                            do b = 8'($urandom); while (b == CHAR_LF);
                            msg_bytes.push_back(b);
                        end
                    end else begin
                        push_crlf();
                    end
                end
                // Last chunk, then either an immediate CR LF or trailer lines.
                push_size(36'd0);
                push_line_tail();
                push_crlf();
                if ($urandom_range(1)) begin
                    repeat ($urandom_range(1, 2)) begin
                        push_printable($urandom_range(1, 10));
                        push_crlf();
                    end
                end
                push_crlf();
                if (flaw == FLAW_TRUNCATE)
                    msg_bytes = msg_bytes[0:$urandom_range(0, msg_bytes.size() - 1)];
                if (flaw == FLAW_GARBLE)
                    msg_bytes[$urandom_range(0, msg_bytes.size() - 1)] = 8'($urandom);
            end
        endcase
        send_queued(with_restart);
    endtask

    // Stimulus and verdict.
    initial begin : stimulus
        int phase_start;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // One-byte chunk of 0xFF, immediate end, then a byte after completion.
        msg_bytes.delete();
        push_text("1");
        push_crlf();
        msg_bytes.push_back(8'hff);
        push_crlf();
        push_text("0");
        push_crlf();
        push_crlf();
        msg_bytes.push_back(8'h00);
        send_queued(1'b1);

        // Size line with no digit, then a byte after the error.
        msg_bytes.delete();
        push_crlf();
        msg_bytes.push_back(8'hff);
        send_queued(1'b1);

        // Leading zero, a lone LF in the size line, then a bad data terminator.
        msg_bytes.delete();
        push_text("01");
        msg_bytes.push_back(CHAR_LF);
        push_crlf();
        msg_bytes.push_back(8'h00);
        push_text("X");
        send_queued(1'b1);

        // Random bodies, one max_body setting per phase.
        foreach (body_limits[p]) begin
            write_max_body(body_limits[p]);
            idle_on <= (p != 3);
            if (p == 3) stall_req <= 1'b1;
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) send_message();
        end

        drain();
        repeat (8) @(posedge aclk);
        if (fail_count == 0)
            $display("** http_chunked_body_decoder: PASSED **");
        else
            $display("** http_chunked_body_decoder: FAILED **");
        $finish;
    end

endmodule
